// ===== design/spad_pkg.sv =====
// Package for subset_preimage_avoid_depth: payload structs, sizes and the
// controller/datapath command and status structs. No dependencies.
package spad_pkg;
  localparam int unsigned NumStates = 12;
  localparam int unsigned SetW      = NumStates;
  localparam int unsigned SetCount  = 1 << NumStates;
  localparam int unsigned StateW    = 4;
  localparam int unsigned MapW      = NumStates * StateW;
  localparam int unsigned LimW      = 12;
  localparam int unsigned DistW     = 13;
  localparam int unsigned PtrW      = SetW + 1;

  typedef struct packed {
    logic [MapW-1:0]   map_a;
    logic [MapW-1:0]   map_b;
    logic [StateW-1:0] target;
    logic              all_targets;
    logic [LimW-1:0]   depth_limit;
  } req_t;

  typedef struct packed {
    logic [DistW-1:0] distance;
    logic             exceeded;
  } rsp_t;

  typedef struct packed {
    logic load;        // capture request, build preimages
    logic clr_step;    // clear one visited entry
    logic start;       // seed queue with start subset
    logic rd;          // issue queue read at head
    logic expand;      // compute preimages of read subset
    logic push_a;      // visit/push subset a
    logic push_b;      // visit/push subset b
    logic level_done;  // advance level
    logic finish_hit;  // search ended with empty preimage
    logic finish_lim;  // search ended by limit or exhaustion
    logic next_target;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic level_empty;  // head reached level end
    logic queue_empty;  // head == tail at level boundary
    logic limit_hit;
    logic pre_empty;
    logic last_target;
  } sts_t;
endpackage

// ===== design/spad_datapath.sv =====
// Datapath: preimage tables, visited map, subset queue, counters.
// Depends on spad_pkg.
module spad_datapath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  spad_pkg::req_t req_i,
  input  spad_pkg::cmd_t cmd_i,
  output spad_pkg::sts_t sts_o,
  output spad_pkg::rsp_t rsp_o
);
  import spad_pkg::*;

  logic [SetW-1:0] pre_a_q [NumStates];
  logic [SetW-1:0] pre_b_q [NumStates];
  logic [SetW-1:0] pre_a_d [NumStates];
  logic [SetW-1:0] pre_b_d [NumStates];
  logic            all_q;
  logic [StateW-1:0] target_q, tgt_q;
  logic [LimW-1:0] limit_q, level_q;
  logic [PtrW-1:0] head_q, tail_q, end_q;
  logic [SetW-1:0] clr_q;
  logic            clr_done_q;
  logic [SetW-1:0] cur_q, u_q, v_q;
  logic [DistW-1:0] best_q;
  logic            exc_q;

  logic            visited [SetCount];
  logic [SetW-1:0] queue [SetCount];
  logic            vis_u_q, vis_v_q;

  logic [SetW-1:0] u_d, v_d, start_set;
  logic [DistW-1:0] dist_cand;

  logic push_a_en, push_b_en;
  logic push_a_q;

  always_comb begin
    u_d = '0;
    v_d = '0;
    for (int j = 0; j < NumStates; j++) begin
      if (cur_q[j]) begin
        u_d = u_d | pre_a_q[j];
        v_d = v_d | pre_b_q[j];
      end
    end
  end

  always_comb begin
    start_set = '0;
    if (all_q) start_set[tgt_q] = 1'b1;
    else if (target_q < StateW'(NumStates)) start_set[target_q] = 1'b1;
  end

  always_comb begin
    if (cmd_i.finish_hit) dist_cand = DistW'(level_q) + DistW'(1);
    else dist_cand = DistW'(limit_q) + DistW'(1);
  end

  // out-of-range next states land in no preimage
  always_comb begin
    for (int i = 0; i < NumStates; i++) begin
      pre_a_d[i] = '0;
      pre_b_d[i] = '0;
      for (int k = 0; k < NumStates; k++) begin
        if (req_i.map_a[k*StateW +: StateW] == StateW'(i)) pre_a_d[i][k] = 1'b1;
        if (req_i.map_b[k*StateW +: StateW] == StateW'(i)) pre_b_d[i][k] = 1'b1;
      end
    end
  end

  // preimage tables
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int i = 0; i < NumStates; i++) begin
        pre_a_q[i] <= pre_a_d[i];
        pre_b_q[i] <= pre_b_d[i];
      end
      all_q    <= req_i.all_targets;
      target_q <= req_i.target;
      limit_q  <= req_i.depth_limit;
    end
  end

  // visited map and queue memories; reads registered
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) visited[clr_q] <= 1'b0;
    else if (cmd_i.start) visited[start_set] <= 1'b1;
    else if (cmd_i.push_a) visited[u_q] <= 1'b1;
    else if (cmd_i.push_b) visited[v_q] <= 1'b1;
    if (cmd_i.expand) begin
      vis_u_q <= visited[u_d];
      vis_v_q <= visited[v_d];
    end
  end

  assign push_a_en = cmd_i.push_a && !vis_u_q && tail_q < PtrW'(SetCount);
  assign push_b_en = cmd_i.push_b && !vis_v_q && !(u_q == v_q && push_a_q)
                     && tail_q < PtrW'(SetCount);

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) queue[0] <= start_set;
    else if (push_a_en) queue[tail_q[SetW-1:0]] <= u_q;
    else if (push_b_en) queue[tail_q[SetW-1:0]] <= v_q;
    if (cmd_i.rd) cur_q <= queue[head_q[SetW-1:0]];
    if (cmd_i.expand) begin
      u_q <= u_d;
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0; tail_q <= '0; end_q <= '0; level_q <= '0;
      clr_q <= '0; clr_done_q <= 1'b0; tgt_q <= '0;
      best_q <= '0; exc_q <= 1'b0; push_a_q <= 1'b0;
    end else begin
      if (cmd_i.push_a) push_a_q <= push_a_en;
      if (cmd_i.load) begin
        tgt_q <= '0; best_q <= '0; exc_q <= 1'b0;
        clr_q <= '0; clr_done_q <= 1'b0;
      end
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + SetW'(1);
        clr_done_q <= (clr_q == SetW'(SetCount - 1));
      end
      if (cmd_i.start) begin
        head_q <= '0; tail_q <= PtrW'(1); end_q <= PtrW'(1); level_q <= '0;
      end
      if (cmd_i.rd) head_q <= head_q + PtrW'(1);
      if (push_a_en || push_b_en) tail_q <= tail_q + PtrW'(1);
      if (cmd_i.level_done) begin
        level_q <= level_q + LimW'(1);
        end_q   <= tail_q;
      end
      if (cmd_i.finish_hit || cmd_i.finish_lim) begin
        if (dist_cand > best_q) best_q <= dist_cand;
        if (cmd_i.finish_lim) exc_q <= 1'b1;
        clr_q <= '0; clr_done_q <= 1'b0;
      end
      if (cmd_i.next_target) tgt_q <= tgt_q + StateW'(1);
    end
  end

  assign sts_o.clr_done    = clr_done_q;
  assign sts_o.level_empty = (head_q == end_q);
  assign sts_o.queue_empty = (head_q == tail_q);
  assign sts_o.limit_hit   = (level_q >= limit_q);
  assign sts_o.pre_empty   = (u_q == '0) || (v_q == '0);
  assign sts_o.last_target = !all_q || (tgt_q == StateW'(NumStates - 1));
  assign rsp_o.distance    = best_q;
  assign rsp_o.exceeded    = exc_q;
endmodule

// ===== design/spad_ctrl.sv =====
// Controller state machine sequencing clear, search levels and targets.
// Depends on spad_pkg.
module spad_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  output logic           rsp_valid_o,
  input  logic           rsp_ready_i,
  input  spad_pkg::sts_t sts_i,
  output spad_pkg::cmd_t cmd_o
);
  import spad_pkg::*;

  localparam logic [3:0] SIdle = 4'd0, SClr = 4'd1, SStart = 4'd2, SChk = 4'd3,
                         SRd = 4'd4, SExp = 4'd5, STest = 4'd6, SPushA = 4'd7,
                         SPushB = 4'd8, SEnd = 4'd9, SOut = 4'd10;
  logic [3:0] state_q, state_d;

  assign req_ready_o = (state_q == SIdle);
  assign rsp_valid_o = (state_q == SOut);

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    unique case (state_q)
      SIdle: if (req_valid_i) begin cmd_o.load = 1'b1; state_d = SClr; end
      SClr: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) begin cmd_o.clr_step = 1'b0; state_d = SStart; end
      end
      SStart: begin cmd_o.start = 1'b1; state_d = SChk; end
      SChk: begin
        // loop condition: queue not exhausted and below limit
        if (sts_i.queue_empty || sts_i.limit_hit) begin
          cmd_o.finish_lim = 1'b1; state_d = SEnd;
        end else state_d = SRd;
      end
      SRd: begin
        if (sts_i.level_empty) begin cmd_o.level_done = 1'b1; state_d = SChk; end
        else begin cmd_o.rd = 1'b1; state_d = SExp; end
      end
      SExp: begin cmd_o.expand = 1'b1; state_d = STest; end
      STest: begin
        if (sts_i.pre_empty) begin cmd_o.finish_hit = 1'b1; state_d = SEnd; end
        else state_d = SPushA;
      end
      SPushA: begin cmd_o.push_a = 1'b1; state_d = SPushB; end
      SPushB: begin cmd_o.push_b = 1'b1; state_d = SRd; end
      SEnd: begin
        if (sts_i.last_target) state_d = SOut;
        else begin cmd_o.next_target = 1'b1; state_d = SClr; end
      end
      SOut: if (rsp_ready_i) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= SIdle;
    else state_q <= state_d;
  end
endmodule

// ===== design/subset_preimage_avoid_depth_top.sv =====
// Usage: one request on req (valid/ready) carries two next-state maps, a
// target, a mode bit and a depth limit; one response on rsp (valid/ready)
// returns distance and exceeded.
// Each search first clears the 4096-entry visited map, one entry per cycle,
// then walks the subset queue breadth first with registered visited and queue
// memory accesses. All-targets mode runs twelve such searches back to back.
// One request is in flight at a time; req_ready is high only when idle.
// The response holds until taken; a stalled receiver blocks new requests.
// Reset returns the controller to idle with no response pending.
module subset_preimage_avoid_depth_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  spad_pkg::req_t req_i,
  output logic           rsp_valid_o,
  input  logic           rsp_ready_i,
  output spad_pkg::rsp_t rsp_o
);
  import spad_pkg::*;

  cmd_t cmd;
  sts_t sts;

  spad_ctrl u_ctrl (
    .clk_i, .rst_ni, .req_valid_i, .req_ready_o, .rsp_valid_o, .rsp_ready_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  spad_datapath u_dp (
    .clk_i, .rst_ni, .req_i, .cmd_i(cmd), .sts_o(sts), .rsp_o
  );
endmodule

// ===== verif/spad_checker.sv =====
// Checker for subset_preimage_avoid_depth_top: watches the request and response
// channels, predicts each response with its own subset search and compares it.
// Depends on spad_pkg for the payload structs and sizes.
module spad_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  input  logic           req_ready_i,
  input  spad_pkg::req_t req_i,
  input  logic           rsp_valid_i,
  input  logic           rsp_ready_i,
  input  spad_pkg::rsp_t rsp_i,
  output int             fail_count_o,
  output int             pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import spad_pkg::*;

  rsp_t         expected_rsp_q[$];
  logic [SetW-1:0] pre_a[NumStates];
  logic [SetW-1:0] pre_b[NumStates];
  logic         seen_set[SetCount];
  logic [SetW-1:0] set_fifo[SetCount];

  function automatic void build_pre(input logic [MapW-1:0] map,
                                    output logic [SetW-1:0] pre[NumStates]);
    logic [StateW-1:0] nxt;
    for (int i = 0; i < NumStates; i++) pre[i] = '0;
    for (int i = 0; i < NumStates; i++) begin
      nxt = map[StateW*i +: StateW];
      if (nxt < NumStates) pre[nxt][i] = 1'b1;
    end
  endfunction

  function automatic logic [SetW-1:0] pre_of_set(input logic [SetW-1:0] s,
                                                 input logic [SetW-1:0] pre[NumStates]);
    logic [SetW-1:0] r;
    r = '0;
    for (int j = 0; j < NumStates; j++) if (s[j]) r |= pre[j];
    return r;
  endfunction

  // Breadth-first over subsets; returns level of first empty preimage plus one, else limit plus one.
  function automatic logic [DistW-1:0] avoid_depth(input logic [SetW-1:0] start,
                                                 input logic [LimW-1:0] lim);
    int head, tail, stop, lvl;
    logic [SetW-1:0] s, u, v;
    for (int k = 0; k < SetCount; k++) seen_set[k] = 1'b0;
    head = 0;
    tail = 0;
    lvl  = 0;
    set_fifo[tail++] = start;
    seen_set[start] = 1'b1;
    while (head < tail && lvl < lim) begin
      stop = tail;
      while (head < stop) begin
        s = set_fifo[head++];
        u = pre_of_set(s, pre_a);
        v = pre_of_set(s, pre_b);
        if (u == '0 || v == '0) return DistW'(lvl + 1);
        if (!seen_set[u] && tail < SetCount) begin
          seen_set[u] = 1'b1;
          set_fifo[tail++] = u;
        end
        if (!seen_set[v] && tail < SetCount) begin
          seen_set[v] = 1'b1;
          set_fifo[tail++] = v;
        end
      end
      lvl++;
    end
    return DistW'(lim) + 1'b1;
  endfunction

  function automatic rsp_t predict_rsp(input req_t r);
    rsp_t o;
    logic [DistW-1:0] d;
    logic [SetW-1:0] st;
    build_pre(r.map_a, pre_a);
    build_pre(r.map_b, pre_b);
    o = '0;
    if (r.all_targets) begin
      for (int q = 0; q < NumStates; q++) begin
        d = avoid_depth(SetW'(1) << q, r.depth_limit);
        if (d > r.depth_limit) o.exceeded = 1'b1;
        if (d > o.distance) o.distance = d;
      end
    end else begin
      st = (r.target < NumStates) ? (SetW'(1) << r.target) : '0;
      o.distance = avoid_depth(st, r.depth_limit);
      o.exceeded = (o.distance > r.depth_limit);
    end
    return o;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    rsp_t exp_r;
    int   errs;
    if (!rst_ni) begin
      fail_count_o <= 0;
    end else begin
      errs = 0;
      if (req_valid_i && req_ready_i) expected_rsp_q = {expected_rsp_q, predict_rsp(req_i)};
      if (rsp_valid_i && rsp_ready_i) begin
        if (expected_rsp_q.size() == 0) begin
          $error("response with no request outstanding");
          errs = errs + 1;
        end else begin
          exp_r = expected_rsp_q.pop_front();
          if (exp_r.distance !== rsp_i.distance) begin
            $error("distance: expected %0d, actual %0d", exp_r.distance, rsp_i.distance);
            errs = errs + 1;
          end
          if (exp_r.exceeded !== rsp_i.exceeded) begin
            $error("exceeded: expected %0d, actual %0d", exp_r.exceeded, rsp_i.exceeded);
            errs = errs + 1;
          end
        end
      end
      fail_count_o <= fail_count_o + errs;
    end
  end

  assign pending_o = expected_rsp_q.size();
endmodule

// ===== verif/subset_preimage_avoid_depth_top_test.sv =====
// Testbench top for subset_preimage_avoid_depth_top: directed and random requests
// with idling and back-pressure; spad_checker does the prediction and comparison.
// Depends on spad_pkg, spad_checker and the block under test.
module subset_preimage_avoid_depth_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import spad_pkg::*;

  localparam int unsigned MaxCycles = 100000000;
  localparam int unsigned HoldCycles = 20000;

  logic clk_i, rst_ni;
  logic req_valid_i, req_ready_o, rsp_valid_o;
  logic rsp_ready_i = 1'b0;
  req_t req_i;
  rsp_t rsp_o;
  int   fail_count, pending;
  int   tx_idle, rx_idle;
  logic rx_hold_req;
  int   hold_left = 0;
  int unsigned cycle_cnt = 0;

  subset_preimage_avoid_depth_top u_dut (
    .clk_i, .rst_ni, .req_valid_i, .req_ready_o, .req_i,
    .rsp_valid_o, .rsp_ready_i, .rsp_o
  );

  spad_checker u_checker (
    .clk_i, .rst_ni,
    .req_valid_i, .req_ready_i(req_ready_o), .req_i,
    .rsp_valid_i(rsp_valid_o), .rsp_ready_i, .rsp_i(rsp_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MaxCycles) begin
      $display("** subset_preimage_avoid_depth_top: FAILED **");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  always @(negedge clk_i) begin
    if (rx_hold_req && hold_left == 0) hold_left <= HoldCycles;
    if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      rsp_ready_i <= 1'b0;
    end else begin
      rsp_ready_i <= ($urandom_range(0, 99) >= rx_idle);
    end
  end

  function automatic logic [MapW-1:0] rand_map(input bit in_range);
    logic [MapW-1:0] m;
    for (int i = 0; i < NumStates; i++)
      m[StateW*i +: StateW] = in_range ? StateW'($urandom_range(0, NumStates - 1))
                                       : StateW'($urandom_range(0, 15));
    return m;
  endfunction

  function automatic logic [MapW-1:0] perm_map();
    logic [StateW-1:0] p[NumStates];
    logic [StateW-1:0] t;
    logic [MapW-1:0]   m;
    int j;
    for (int i = 0; i < NumStates; i++) p[i] = StateW'(i);
    for (int i = NumStates - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = p[i]; p[i] = p[j]; p[j] = t;
    end
    for (int i = 0; i < NumStates; i++) m[StateW*i +: StateW] = p[i];
    return m;
  endfunction

  function automatic logic [MapW-1:0] ident_map();
    logic [MapW-1:0] m;
    for (int i = 0; i < NumStates; i++) m[StateW*i +: StateW] = StateW'(i);
    return m;
  endfunction

  // Cycle on letter a, merge of two states on letter b: deep but synchronizing.
  function automatic logic [MapW-1:0] rot_map();
    logic [MapW-1:0] m;
    for (int i = 0; i < NumStates; i++) m[StateW*i +: StateW] = StateW'((i + 1) % NumStates);
    return m;
  endfunction

  task automatic send_req(input logic [MapW-1:0] ma, input logic [MapW-1:0] mb,
                          input logic [StateW-1:0] tg, input logic all_t,
                          input logic [LimW-1:0] lim);
    while ($urandom_range(0, 99) < tx_idle) begin
      req_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    req_valid_i       <= 1'b1;
    req_i.map_a       <= ma;
    req_i.map_b       <= mb;
    req_i.target      <= tg;
    req_i.all_targets <= all_t;
    req_i.depth_limit <= lim;
    // ready only changes at the rising edge, so the falling edge sees what the next edge sees
    while (!req_ready_o) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain_rsp();
    req_valid_i <= 1'b0;
    while (pending != 0 || rsp_valid_o) @(negedge clk_i);
  endtask

  initial begin
    logic [MapW-1:0] merge_b, ma, mb;
    logic [LimW-1:0] lim;
    logic all_t;
    int sel;
    rst_ni      = 1'b0;
    req_valid_i = 1'b0;
    req_i       = '0;
    rx_hold_req = 1'b0;
    tx_idle     = 7;
    rx_idle     = 56;
    merge_b = ident_map();
    merge_b[StateW*1 +: StateW] = 4'd0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: field extremes and the special cases.
    send_req(ident_map(), ident_map(), 4'd0, 1'b0, 12'd1);
    send_req(ident_map(), ident_map(), 4'd11, 1'b0, 12'd4095);    // exhausted subsets
    send_req('0, '0, 4'd5, 1'b0, 12'd10);                        // empty preimage at once
    send_req({MapW{1'b1}}, {MapW{1'b1}}, 4'd3, 1'b0, 12'd4095);  // all nibbles out of range
    send_req({MapW{1'b1}}, '0, 4'd0, 1'b0, 12'd2);
    send_req(ident_map(), ident_map(), 4'd12, 1'b0, 12'd7);      // target out of range
    send_req(ident_map(), ident_map(), 4'd15, 1'b0, 12'd4095);
    send_req(rot_map(), merge_b, 4'd0, 1'b0, 12'd4095);
    send_req(rot_map(), merge_b, 4'd1, 1'b0, 12'd20);
    send_req(rot_map(), merge_b, 4'd0, 1'b1, 12'd4095);          // all targets, deep
    send_req(ident_map(), ident_map(), 4'd0, 1'b1, 12'd1);
    send_req('0, ident_map(), 4'd9, 1'b1, 12'd3);
    send_req(perm_map(), rand_map(1), 4'd7, 1'b0, 12'd2048);
    send_req(perm_map(), perm_map(), 4'd4, 1'b0, 12'd1365);
    send_req(rand_map(0), rand_map(0), 4'd13, 1'b0, 12'd2730);

    // Send requests while the receiver holds off; the block takes one at a time.
    rx_hold_req = 1'b1;
    send_req(rand_map(1), rand_map(1), 4'd2, 1'b0, 12'd5);
    send_req(rand_map(1), rand_map(1), 4'd6, 1'b0, 12'd5);
    send_req(rand_map(1), rand_map(1), 4'd8, 1'b0, 12'd5);
    rx_hold_req = 1'b0;
    // Pause until every response is back.
    drain_rsp();

    for (int n = 0; n < 85; n++) begin
      if (n == 28) begin
        tx_idle = 56;
        rx_idle = 7;
      end else if (n == 56) begin
        tx_idle = 0;
        rx_idle = 0;
      end
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        ma = perm_map();
        mb = rand_map(1);
      end else if (sel < 80) begin
        ma = rand_map(1);
        mb = rand_map(1);
      end else begin
        ma = rand_map(0);
        mb = rand_map(0);
      end
      if ($urandom_range(0, 1)) begin
        logic [MapW-1:0] t;
        t = ma; ma = mb; mb = t;
      end
      all_t = ($urandom_range(0, 11) == 0);
      lim = ($urandom_range(0, 9) == 0 && !all_t) ? LimW'($urandom_range(1, 4095))
                                                   : LimW'($urandom_range(1, 20));
      send_req(ma, mb, StateW'($urandom_range(0, 15)), all_t, lim);
    end
    req_valid_i <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    if (fail_count == 0 && !rsp_valid_o) begin
      $display("** subset_preimage_avoid_depth_top: PASSED **");
    end else begin
      $display("** subset_preimage_avoid_depth_top: FAILED **");
    end
    $finish;
  end
endmodule
